// ----- hw/rtl/sdl_pkg.sv -----
// Shared types and constants for the switch debounce and long-press block.
package sdl_pkg;

    localparam int SWITCH_COUNT_DEF = 8;   // default number of switches
    localparam int SWITCH_COUNT_MAX = 8;   // pin word width bounds the count
    localparam int PIN_W            = 8;   // raw_pins and debounced_state width
    localparam int CMD_W            = 3;
    localparam int IDX_W            = 3;
    localparam int HOLD_W           = 8;   // hold counter and threshold width

    localparam logic [HOLD_W-1:0] LONG_PRESS_RST = 8'd50;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_TAKE_PRESS = 3'd1,
        CMD_TAKE_REL   = 3'd2,
        CMD_TAKE_LONG  = 3'd3,
        CMD_READ_STATE = 3'd4
    } t_cmd;

endpackage

// ----- hw/rtl/switch_debounce_longpress.sv -----
// Switch debouncer with press, release and long-press flags: top level.
//
//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+-----------------------------------
//  input    | in        | i_valid / o_stall      | i_command, i_raw_pins, i_switch_index
//  result   | out       | o_valid / i_stall      | o_answer, o_debounced_state
//  config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_data (long_press_ticks)
//
// One word per cycle sustained while the result side does not stall. A taken word
// passes from the input register into the result register, which drives o_valid.
// Stage 1 is an input register, stage 2 updates all switch state in one pass
// and loads the result register. Both stages advance together whenever the
// result register is empty or being taken, so back-pressure only stalls the
// input when both stages are full. Reset is synchronous: flags and state clear,
// vertical counters go to all ones, threshold to 50. Config is always ready.
module switch_debounce_longpress #(
    parameter int SWITCH_COUNT = sdl_pkg::SWITCH_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sdl_pkg::CMD_W-1:0]     i_command,
    input  logic [sdl_pkg::PIN_W-1:0]     i_raw_pins,
    input  logic [sdl_pkg::IDX_W-1:0]     i_switch_index,
    // result words
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_answer,
    output logic [sdl_pkg::PIN_W-1:0]     o_debounced_state,
    // threshold register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sdl_pkg::HOLD_W-1:0]    i_cfg_data
);

    localparam int SW = SWITCH_COUNT;
    localparam int HW = sdl_pkg::HOLD_W;

    // ---------------- control ----------------
    logic r_in_vld, r_out_vld;
    logic adv;        // stage 2 may load the result register
    logic in_take;

    assign adv      = !r_out_vld || !i_stall;
    assign o_stall  = r_in_vld && !adv;
    assign in_take  = i_valid && !o_stall;
    assign o_valid  = r_out_vld;
    assign o_cfg_ready = 1'b1;

    // ---------------- input register ----------------
    logic [sdl_pkg::CMD_W-1:0] r_cmd;
    logic [SW-1:0]             r_raw;
    logic [sdl_pkg::IDX_W-1:0] r_idx;

    // ---------------- state ----------------
    logic [HW-1:0] r_long_press_ticks;
    logic [SW-1:0] r_pressed, n_pressed;
    logic [SW-1:0] r_cnt_lo, n_cnt_lo;
    logic [SW-1:0] r_cnt_hi, n_cnt_hi;
    logic [SW-1:0] r_press_flg, n_press_flg;
    logic [SW-1:0] r_rel_flg, n_rel_flg;
    logic [SW-1:0] r_long_flg, n_long_flg;
    logic [HW-1:0] r_hold [SW];
    logic [HW-1:0] n_hold [SW];

    logic          r_answer, n_answer;

    // ---------------- tick datapath ----------------
    logic [SW-1:0] change, t_lo, t_hi, flips, t_pressed, presses, releases;
    logic [SW-1:0] long_hit;
    logic [HW-1:0] hold_tick [SW];
    logic [SW-1:0] sel;         // one-hot switch select, zero when index out of range

    // 2-bit vertical counter per switch: counts the ticks a difference persists
    assign change    = r_pressed ^ ~r_raw;
    assign t_lo      = ~(r_cnt_lo & change);
    assign t_hi      = t_lo ^ (r_cnt_hi & change);
    assign flips     = change & t_lo & t_hi;
    assign t_pressed = r_pressed ^ flips;
    assign presses   = flips & t_pressed;
    assign releases  = flips & ~t_pressed;

    for (genvar g = 0; g < SW; g++) begin : g_lane
        logic [HW-1:0] base;
        logic [HW-1:0] inc;
        logic          run;
        // a fresh press restarts the hold count and counts on the same tick
        assign base = presses[g] ? '0 : r_hold[g];
        assign inc  = base + HW'(1);
        assign run  = t_pressed[g] && (base < r_long_press_ticks);
        assign hold_tick[g] = run ? inc : base;
        assign long_hit[g]  = run && (inc == r_long_press_ticks);
        assign sel[g]       = (r_idx == sdl_pkg::IDX_W'(g));
    end

    // ---------------- next-state selection ----------------
    always_comb begin
        n_pressed   = r_pressed;
        n_cnt_lo    = r_cnt_lo;
        n_cnt_hi    = r_cnt_hi;
        n_press_flg = r_press_flg;
        n_rel_flg   = r_rel_flg;
        n_long_flg  = r_long_flg;
        n_answer    = 1'b0;
        for (int k = 0; k < SW; k++) begin
            n_hold[k] = r_hold[k];
        end
        if (r_in_vld && adv) begin
            unique case (sdl_pkg::t_cmd'(r_cmd))
                sdl_pkg::CMD_TICK: begin
                    n_pressed   = t_pressed;
                    n_cnt_lo    = t_lo;
                    n_cnt_hi    = t_hi;
                    n_press_flg = r_press_flg | presses;
                    n_rel_flg   = r_rel_flg | releases;
                    n_long_flg  = r_long_flg | long_hit;
                    for (int k = 0; k < SW; k++) begin
                        n_hold[k] = hold_tick[k];
                    end
                end
                sdl_pkg::CMD_TAKE_PRESS: begin
                    n_answer    = |(r_press_flg & sel);
                    n_press_flg = r_press_flg & ~sel;
                end
                sdl_pkg::CMD_TAKE_REL: begin
                    n_answer  = |(r_rel_flg & sel);
                    n_rel_flg = r_rel_flg & ~sel;
                end
                sdl_pkg::CMD_TAKE_LONG: begin
                    n_answer   = |(r_long_flg & sel);
                    n_long_flg = r_long_flg & ~sel;
                end
                sdl_pkg::CMD_READ_STATE: begin
                    n_answer = |(r_pressed & sel);
                end
                default: begin
                    n_answer = 1'b0;    // unused commands change nothing
                end
            endcase
        end
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld           <= 1'b0;
            r_out_vld          <= 1'b0;
            r_long_press_ticks <= sdl_pkg::LONG_PRESS_RST;
            r_pressed          <= '0;
            r_cnt_lo           <= '1;
            r_cnt_hi           <= '1;
            r_press_flg        <= '0;
            r_rel_flg          <= '0;
            r_long_flg         <= '0;
            for (int k = 0; k < SW; k++) begin
                r_hold[k] <= '0;
            end
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_long_press_ticks <= i_cfg_data;
            end
            r_pressed   <= n_pressed;
            r_cnt_lo    <= n_cnt_lo;
            r_cnt_hi    <= n_cnt_hi;
            r_press_flg <= n_press_flg;
            r_rel_flg   <= n_rel_flg;
            r_long_flg  <= n_long_flg;
            for (int k = 0; k < SW; k++) begin
                r_hold[k] <= n_hold[k];
            end
        end
    end

    // ---------------- payload registers ----------------
    logic [SW-1:0] r_state_out;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd <= i_command;
            r_raw <= i_raw_pins[SW-1:0];     // pins above the switch count are dropped
            r_idx <= i_switch_index;
        end
        if (r_in_vld && adv) begin
            r_answer    <= n_answer;
            r_state_out <= n_pressed;
        end
    end

    assign o_answer          = r_answer;
    assign o_debounced_state = sdl_pkg::PIN_W'(r_state_out);

endmodule

// ----- hw/rtl/sdl_checker.sv -----
// Port-level checker for the switch debounce block, with its bind.
module sdl_checker #(
    parameter int SWITCH_COUNT = sdl_pkg::SWITCH_COUNT_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic                       o_answer,
    input logic [sdl_pkg::PIN_W-1:0]  o_debounced_state
);

    // nothing is pending right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // held result word must not move
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_answer)
                                  && $stable(o_debounced_state)))
        else $error("stalled result changed");

    // input only stalls when the result register is full and held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

    // an accepted word moves from the input register into the result register when that is free
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall |=> o_valid)
        else $error("accepted word not delivered");

    // switches beyond the configured count never read as pressed
    a_unused_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_debounced_state >> SWITCH_COUNT) == '0))
        else $error("unused switch shows pressed");

endmodule

bind switch_debounce_longpress sdl_checker #(
    .SWITCH_COUNT (SWITCH_COUNT)
) u_sdl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_answer          (o_answer),
    .o_debounced_state (o_debounced_state)
);

// ----- test/tb_top.sv -----
// Self-checking bench for the switch debouncer: predicts each result word and compares it.
`timescale 1ns / 100ps

import sdl_pkg::*;

typedef struct packed {
    logic             answer;
    logic [PIN_W-1:0] pressed;
} t_switch_answer;

// Tracks debounced state, sticky flags and hold counts; queues expected words.
class switch_event_tracker;
    logic [HOLD_W-1:0] threshold;
    logic [PIN_W-1:0]  sw_mask;
    logic [PIN_W-1:0]  pressed;
    logic [PIN_W-1:0]  cnt_lo;
    logic [PIN_W-1:0]  cnt_hi;
    logic [PIN_W-1:0]  press_flags;
    logic [PIN_W-1:0]  release_flags;
    logic [PIN_W-1:0]  long_flags;
    logic [HOLD_W-1:0] hold_cnt [PIN_W];
    t_switch_answer    expected_answers [$];
    int                mismatches;

    function new();
        for (int i = 0; i < PIN_W; i++) begin
            sw_mask[i]  = (i < SWITCH_COUNT_DEF);
            hold_cnt[i] = '0;
        end
        threshold     = LONG_PRESS_RST;
        pressed       = '0;
        cnt_lo        = sw_mask;
        cnt_hi        = sw_mask;
        press_flags   = '0;
        release_flags = '0;
        long_flags    = '0;
        mismatches    = 0;
    endfunction

    function void set_threshold(input logic [HOLD_W-1:0] value);
        threshold = value;
    endfunction

    function int pending();
        return expected_answers.size();
    endfunction

    // One tick of the 2-bit vertical counters plus hold counting.
    function void debounce_tick(input logic [PIN_W-1:0] raw);
        logic [PIN_W-1:0] change;
        logic [PIN_W-1:0] flips;
        logic [PIN_W-1:0] presses;
        change   = (pressed ^ ~raw) & sw_mask;
        cnt_lo   = ~(cnt_lo & change) & sw_mask;
        cnt_hi   = (cnt_lo ^ (cnt_hi & change)) & sw_mask;
        flips    = change & cnt_lo & cnt_hi;
        pressed  = pressed ^ flips;
        presses  = flips & pressed;
        press_flags   = press_flags | presses;
        release_flags = release_flags | (flips & ~pressed);
        for (int i = 0; i < SWITCH_COUNT_DEF; i++) begin
            if (presses[i])
                hold_cnt[i] = '0;
            if (pressed[i] && hold_cnt[i] < threshold) begin
                hold_cnt[i] = hold_cnt[i] + 1'b1;
                if (hold_cnt[i] == threshold)
                    long_flags[i] = 1'b1;
            end
        end
    endfunction

    function void note_word(input logic [CMD_W-1:0] cmd, input logic [PIN_W-1:0] raw,
                            input logic [IDX_W-1:0] idx);
        t_switch_answer w;
        w.answer = 1'b0;
        if (cmd == CMD_TICK) begin
            debounce_tick(raw);
        end else if (idx < SWITCH_COUNT_DEF) begin
            case (cmd)
                CMD_TAKE_PRESS: begin
                    w.answer = press_flags[idx];
                    press_flags[idx] = 1'b0;
                end
                CMD_TAKE_REL: begin
                    w.answer = release_flags[idx];
                    release_flags[idx] = 1'b0;
                end
                CMD_TAKE_LONG: begin
                    w.answer = long_flags[idx];
                    long_flags[idx] = 1'b0;
                end
                CMD_READ_STATE: w.answer = pressed[idx];
                default: ;
            endcase
        end
        w.pressed = pressed;
        expected_answers.push_back(w);
    endfunction

    function void check_result(input logic answer, input logic [PIN_W-1:0] state);
        t_switch_answer w;
        if (expected_answers.size() == 0) begin
            $error("result word with nothing expected: answer %0b state %02h", answer, state);
            mismatches++;
            return;
        end
        w = expected_answers.pop_front();
        if (answer !== w.answer) begin
            $error("answer: expected %0b, got %0b", w.answer, answer);
            mismatches++;
        end
        if (state !== w.pressed) begin
            $error("debounced_state: expected %02h, got %02h", w.pressed, state);
            mismatches++;
        end
    endfunction
endclass

module tb_top;

    localparam int LIMIT_CYCLES  = 400_000;
    localparam int SETTLE_CYCLES = 8;        // pipeline is two deep
    // encodings above read-state do nothing and answer 0
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_W'(CMD_READ_STATE + 1);
    localparam logic [CMD_W-1:0] CMD_TOP          = '1;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              o_stall;
    logic [CMD_W-1:0]  i_command      = '0;
    logic [PIN_W-1:0]  i_raw_pins     = '1;
    logic [IDX_W-1:0]  i_switch_index = '0;
    logic              o_valid;
    logic              i_stall        = 1'b0;
    logic              o_answer;
    logic [PIN_W-1:0]  o_debounced_state;
    logic              i_cfg_valid    = 1'b0;
    logic              o_cfg_ready;
    logic [HOLD_W-1:0] i_cfg_data     = '0;

    switch_event_tracker tracker = new();

    // idle likelihood per side, redrawn every 40 words so that busy
    // stretches with no gaps alternate with sparse ones
    int in_pct   = 0;
    int out_pct  = 0;
    int in_sent  = 0;
    int cycles   = 0;

    // pressed pattern the random part holds the pins at, bounces aside
    logic [PIN_W-1:0] held_pattern = '1;

    switch_debounce_longpress #(
        .SWITCH_COUNT(SWITCH_COUNT_DEF)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_raw_pins        (i_raw_pins),
        .i_switch_index    (i_switch_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_answer          (o_answer),
        .o_debounced_state (o_debounced_state),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // hard stop in case a handshake never completes
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int draw_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 20;
            2:       return 50;
            default: return 100;
        endcase
    endfunction

    function automatic int draw_wait(input int pct);
        return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 19) : 0;
    endfunction

    // Present one input word; returns at the edge that takes it. Valid is left
    // high so that back-to-back words need no second assignment in one step.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [PIN_W-1:0] raw,
                             input logic [IDX_W-1:0] idx);
        int gap;
        if (in_sent % 40 == 0)
            in_pct = draw_pct();
        gap = draw_wait(in_pct);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_raw_pins     <= raw;
        i_switch_index <= idx;
        do @(posedge i_clk); while (o_stall);
        tracker.note_word(cmd, raw, idx);
        in_sent++;
    endtask

    // tick with the given pressed pattern; pins are active low
    task automatic tick_with(input logic [PIN_W-1:0] pattern);
        send_word(CMD_TICK, ~pattern, IDX_W'($urandom()));
    endtask

    // Threshold writes only when idle: input dropped, every result back,
    // then a short settle for the pipeline.
    task automatic write_threshold(input logic [HOLD_W-1:0] value);
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.set_threshold(value);
    endtask

    // Mostly ticks at a held pattern with the odd bounce, so switches really
    // debounce and stay held; queries mixed in; a little pure noise.
    task automatic run_random(input int n_words, input logic [PIN_W-1:0] keep);
        int               run_left;
        int               pick;
        logic [PIN_W-1:0] raw;
        run_left = 0;
        for (int k = 0; k < n_words; k++) begin
            if (run_left == 0) begin
                held_pattern = (held_pattern ^ PIN_W'($urandom() & $urandom())) | keep;
                run_left     = $urandom_range(2, 40);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_word(CMD_W'($urandom_range(0, CMD_TOP)), PIN_W'($urandom()),
                          IDX_W'($urandom()));
            end else if (pick < 75) begin
                raw = ~held_pattern;
                if ($urandom_range(0, 9) == 0)
                    raw[$urandom_range(0, PIN_W - 1)] ^= 1'b1;  // bounce
                send_word(CMD_TICK, raw, IDX_W'($urandom()));
            end else begin
                send_word(CMD_W'($urandom_range(CMD_TAKE_PRESS, CMD_READ_STATE)),
                          PIN_W'($urandom()), IDX_W'($urandom()));
            end
        end
    endtask

    // result side: random stall lengths, every accepted word checked
    initial begin : result_sink
        int hold_left;
        int taken;
        hold_left = 0;
        taken     = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                tracker.check_result(o_answer, o_debounced_state);
                taken++;
                if (taken % 40 == 0)
                    out_pct = draw_pct();
                hold_left = draw_wait(out_pct);
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset threshold of 50
        tick_with(8'h00);                                  // all released, nothing moves
        send_word(CMD_READ_STATE, 8'h00, 3'd0);
        repeat (4) tick_with(8'hFF);                       // all press on the fourth tick
        send_word(CMD_TAKE_PRESS, 8'hFF, 3'd0);            // set
        send_word(CMD_TAKE_PRESS, 8'h00, 3'd0);            // already cleared
        send_word(CMD_READ_STATE, 8'hA5, 3'd7);
        send_word(CMD_TAKE_REL, 8'h5A, 3'd7);
        send_word(CMD_UNUSED_FIRST, 8'h00, 3'd2);
        send_word(CMD_TOP, 8'hFF, 3'd7);
        repeat (3) tick_with(8'h55);                       // odd switches start releasing
        tick_with(8'hFF);                                  // bounce back restarts the count
        repeat (4) tick_with(8'h55);                       // now they release
        send_word(CMD_TAKE_REL, 8'h3C, 3'd7);
        send_word(CMD_TAKE_LONG, 8'hC3, 3'd1);

        // threshold 1: even switches are past it and stop; new presses flag
        // long press on the very tick of the press
        write_threshold(8'd1);
        repeat (4) tick_with(8'hFF);
        send_word(CMD_TAKE_LONG, 8'h00, 3'd1);
        send_word(CMD_TAKE_LONG, 8'hFF, 3'd0);
        send_word(CMD_TAKE_PRESS, 8'h0F, 3'd1);

        // random phases; switch 0 held through the longest threshold
        write_threshold(8'd255);
        run_random(480, 8'h01);
        write_threshold(8'd4);                             // below running counts
        run_random(150, '0);
        write_threshold(8'd0);                             // long press disabled
        run_random(120, '0);
        write_threshold(8'd1);
        run_random(120, '0);
        write_threshold(HOLD_W'($urandom_range(2, 30)));
        run_random(150, '0);
        write_threshold(LONG_PRESS_RST);
        run_random(130, '0);

        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sdl_pkg.sv
hw/rtl/switch_debounce_longpress.sv
hw/rtl/sdl_checker.sv
test/tb_top.sv
